/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL files that check their own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define CLNS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define CLNS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/clns_pkg.sv */
`timescale 1ns / 1ps
package clns_pkg;

  // Largest number of cursor-right commands for one set cursor request.
  localparam int MAX_COLUMN = 15;

  localparam int FUNC_W   = 3;
  localparam int BYTE_W   = 8;
  localparam int ROW_W    = 2;
  localparam int COL_W    = 4;
  localparam int NIB_W    = 4;
  localparam int PAT_W    = 6;
  localparam int BEFORE_W = 15;
  localparam int AFTER_W  = 12;
  localparam int LIM_W    = 6;
  localparam int NBYTE_W  = 5;
  localparam int IDX_W    = 4;
  localparam int INIT_LEN = 5;

  localparam logic [BYTE_W-1:0] CMD_4BIT_MODE  = 8'h02;
  localparam logic [BYTE_W-1:0] CMD_FUNC_SET   = 8'h28;
  localparam logic [BYTE_W-1:0] CMD_DISP_ON    = 8'h0C;
  localparam logic [BYTE_W-1:0] CMD_ENTRY_MODE = 8'h06;
  localparam logic [BYTE_W-1:0] CMD_CLEAR      = 8'h01;
  localparam logic [BYTE_W-1:0] CMD_HOME       = 8'h80;
  localparam logic [BYTE_W-1:0] CMD_ROW1       = 8'hC0;
  localparam logic [BYTE_W-1:0] CMD_RIGHT      = 8'h14;

  localparam logic [AFTER_W-1:0]  HOLD_HIGH_US  = 12'd200;
  localparam logic [AFTER_W-1:0]  HOLD_LOW_US   = 12'd2000;
  localparam logic [AFTER_W-1:0]  HOLD_CLEAR_US = 12'd4000;
  localparam logic [BEFORE_W-1:0] POWER_ON_US   = 15'd20000;

  typedef enum logic [FUNC_W-1:0] {
    FN_INIT   = 3'd0,
    FN_CMD    = 3'd1,
    FN_CHAR   = 3'd2,
    FN_CLEAR  = 3'd3,
    FN_CURSOR = 3'd4
  } func_t;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic slot_free;
    logic empty;
    logic final_nib;
  } dp_sts_t;

  function automatic logic [BYTE_W-1:0] init_byte(input logic [IDX_W-1:0] idx);
    logic [BYTE_W-1:0] b;
    case (idx)
      4'd0:    b = CMD_4BIT_MODE;
      4'd1:    b = CMD_FUNC_SET;
      4'd2:    b = CMD_DISP_ON;
      4'd3:    b = CMD_ENTRY_MODE;
      4'd4:    b = CMD_CLEAR;
      default: b = CMD_CLEAR;
    endcase
    return b;
  endfunction

  // Pin map: bit 0 RS, nibble bits 1:0 at bits 2:1, nibble bits 3:2 at bits 5:4.
  function automatic logic [PAT_W-1:0] pin_pattern(input logic rs,
                                                   input logic [NIB_W-1:0] nib);
    return {nib[3:2], 1'b0, nib[1:0], rs};
  endfunction

endpackage

/* hw/rtl/clns_req_if.sv */
`timescale 1ns / 1ps
interface clns_req_if import clns_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [BYTE_W-1:0] data_byte;
  logic [ROW_W-1:0]  row;
  logic [COL_W-1:0]  column;

  modport source (output valid, output func, output data_byte, output row,
                  output column, input ready);
  modport sink (input valid, input func, input data_byte, input row,
                input column, output ready);
endinterface

/* hw/rtl/clns_xfer_if.sv */
`timescale 1ns / 1ps
interface clns_xfer_if import clns_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                rs;
  logic [NIB_W-1:0]    nibble;
  logic [PAT_W-1:0]    port_pattern;
  logic [BEFORE_W-1:0] wait_before_us;
  logic [AFTER_W-1:0]  wait_after_us;
  logic                last;

  modport source (output valid, output rs, output nibble, output port_pattern,
                  output wait_before_us, output wait_after_us, output last,
                  input ready);
  modport sink (input valid, input rs, input nibble, input port_pattern,
                input wait_before_us, input wait_after_us, input last,
                output ready);
endinterface

/* hw/rtl/clns_ctrl.sv */
`timescale 1ns / 1ps
module clns_ctrl import clns_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  dp_sts_t   sts,
  output ctrl_cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        // No transaction is taken while reset is held.
        in_ready = rst_n;
        if (in_valid && rst_n) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts.empty) begin
          state_nxt = ST_IDLE;
        end else if (sts.slot_free) begin
          cmd.emit = 1'b1;
          if (sts.final_nib) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/clns_dp.sv */
`timescale 1ns / 1ps
module clns_dp import clns_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  ctrl_cmd_t           cmd,
  output dp_sts_t             sts,
  input  logic [FUNC_W-1:0]   req_func,
  input  logic [BYTE_W-1:0]   req_data_byte,
  input  logic [ROW_W-1:0]    req_row,
  input  logic [COL_W-1:0]    req_column,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_rs,
  output logic [NIB_W-1:0]    out_nibble,
  output logic [PAT_W-1:0]    out_port_pattern,
  output logic [BEFORE_W-1:0] out_wait_before_us,
  output logic [AFTER_W-1:0]  out_wait_after_us,
  output logic                out_last
);

  func_t               func_r;
  logic [BYTE_W-1:0]   data_r;
  logic                has_addr_r;
  logic [BYTE_W-1:0]   addr_byte_r;
  logic [NBYTE_W-1:0]  n_bytes_r;
  logic [IDX_W-1:0]    idx_r;
  logic                phase_r;

  logic                out_valid_r;
  logic                out_rs_r;
  logic [NIB_W-1:0]    out_nibble_r;
  logic [PAT_W-1:0]    out_pattern_r;
  logic [BEFORE_W-1:0] out_before_r;
  logic [AFTER_W-1:0]  out_after_r;
  logic                out_last_r;

  logic [LIM_W-1:0]    col_ext;
  logic [LIM_W-1:0]    col_sat;
  logic                req_has_addr;
  logic [NBYTE_W-1:0]  req_n_bytes;
  logic [BYTE_W-1:0]   cur_byte;
  logic                cur_rs;
  logic                long_hold;
  logic [NIB_W-1:0]    cur_nib;
  logic                final_nib;

  // Byte count of the incoming request.
  always_comb begin
    col_ext      = LIM_W'(req_column);
    col_sat      = (col_ext > LIM_W'(MAX_COLUMN)) ? LIM_W'(MAX_COLUMN) : col_ext;
    req_has_addr = (req_row == 2'd0) || (req_row == 2'd1);
    case (func_t'(req_func))
      FN_INIT:        req_n_bytes = NBYTE_W'(INIT_LEN);
      FN_CMD, FN_CHAR: req_n_bytes = NBYTE_W'(1);
      FN_CLEAR:       req_n_bytes = NBYTE_W'(2);
      FN_CURSOR:      req_n_bytes = NBYTE_W'(col_sat) + NBYTE_W'(req_has_addr);
      default:        req_n_bytes = '0;
    endcase
  end

  // Byte and hold for the current position in the request.
  always_comb begin
    case (func_r)
      FN_INIT:         cur_byte = init_byte(idx_r);
      FN_CMD, FN_CHAR: cur_byte = data_r;
      FN_CLEAR:        cur_byte = (idx_r == '0) ? CMD_CLEAR : CMD_HOME;
      FN_CURSOR:       cur_byte = (has_addr_r && idx_r == '0) ? addr_byte_r : CMD_RIGHT;
      default:         cur_byte = '0;
    endcase
    cur_rs    = (func_r == FN_CHAR);
    long_hold = ((func_r == FN_INIT) && (idx_r == IDX_W'(INIT_LEN - 1))) ||
                ((func_r == FN_CLEAR) && (idx_r == '0));
    cur_nib   = phase_r ? cur_byte[3:0] : cur_byte[7:4];
    final_nib = phase_r && ((NBYTE_W'(idx_r) + NBYTE_W'(1)) == n_bytes_r);
  end

  assign sts.slot_free = !out_valid_r || out_ready;
  assign sts.empty     = (n_bytes_r == '0);
  assign sts.final_nib = final_nib;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r      <= func_t'(req_func);
      data_r      <= req_data_byte;
      has_addr_r  <= req_has_addr;
      addr_byte_r <= (req_row == 2'd0) ? CMD_HOME : CMD_ROW1;
      n_bytes_r   <= req_n_bytes;
    end
    if (cmd.emit) begin
      out_rs_r      <= cur_rs;
      out_nibble_r  <= cur_nib;
      out_pattern_r <= pin_pattern(cur_rs, cur_nib);
      out_before_r  <= (func_r == FN_INIT && idx_r == '0 && !phase_r) ? POWER_ON_US : '0;
      out_after_r   <= !phase_r ? HOLD_HIGH_US : (long_hold ? HOLD_CLEAR_US : HOLD_LOW_US);
      out_last_r    <= final_nib;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        idx_r   <= '0;
        phase_r <= 1'b0;
      end else if (cmd.emit) begin
        phase_r <= !phase_r;
        if (phase_r) begin
          idx_r <= idx_r + IDX_W'(1);
        end
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_rs             = out_rs_r;
  assign out_nibble         = out_nibble_r;
  assign out_port_pattern   = out_pattern_r;
  assign out_wait_before_us = out_before_r;
  assign out_wait_after_us  = out_after_r;
  assign out_last           = out_last_r;

endmodule

/* hw/rtl/char_lcd_nibble_sequencer_core.sv */
`timescale 1ns / 1ps
// Character LCD sequencer for the 4-bit bus mode of the usual controller.
// in_req takes one request (init, command byte, character byte, clear or
// set cursor); out_xfer gives one transaction per nibble to drive onto the
// pins, with RS, the pin pattern and the waits before and after the enable.
// Both channels use valid/ready; a transaction moves when both are high.
// A request is accepted only while the sequencer is idle. On acceptance
// it is loaded into the datapath registers; the controller then emits
// one nibble per cycle into a single output register while the receiver
// keeps ready high. Init produces 10 nibbles, a byte 2, clear 4 and set
// cursor up to 32; the input is not ready again until the last nibble is
// emitted. A request with no nibbles returns to idle without output.
// The last nibble of each request has last set. When the receiver stalls,
// the output register holds its nibble and the sequencer waits; the next
// request can be accepted while the final nibble of the previous one is
// still waiting. Synchronous reset returns the controller to idle and
// empties the output register.
`include "assert_macros.svh"
module char_lcd_nibble_sequencer_core import clns_pkg::*; (
  input logic         clk,
  input logic         rst_n,
  clns_req_if.sink    in_req,
  clns_xfer_if.source out_xfer
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  clns_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  clns_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .req_func           (in_req.func),
    .req_data_byte      (in_req.data_byte),
    .req_row            (in_req.row),
    .req_column         (in_req.column),
    .out_valid          (out_xfer.valid),
    .out_ready          (out_xfer.ready),
    .out_rs             (out_xfer.rs),
    .out_nibble         (out_xfer.nibble),
    .out_port_pattern   (out_xfer.port_pattern),
    .out_wait_before_us (out_xfer.wait_before_us),
    .out_wait_after_us  (out_xfer.wait_after_us),
    .out_last           (out_xfer.last)
  );

  `CLNS_ASSERT(a_busy_after_accept, in_req.valid && in_req.ready |=> !in_req.ready, "sequencer still ready after accepting a request")
  `CLNS_ASSERT(a_power_on_first_nibble, out_xfer.valid && out_xfer.wait_before_us != '0 |-> !out_xfer.rs && out_xfer.nibble == '0 && out_xfer.wait_after_us == HOLD_HIGH_US, "power-on wait on a nibble that is not the first of init")
  `CLNS_ASSERT(a_pattern_matches, out_xfer.valid |-> out_xfer.port_pattern == pin_pattern(out_xfer.rs, out_xfer.nibble), "pin pattern disagrees with RS and nibble")
  `CLNS_ASSERT_ALWAYS(a_reset_empties, !rst_n |=> !out_xfer.valid, "output valid after reset")

endmodule
